### hw/rtl/tpsfm_pkg.sv
// ----------------------------------------------------------------------------
// tpsfm_pkg : shared types and constants of the fuzzy matcher
// Byte and configuration widths, register indexes, tier codes and the
// structure that carries one candidate byte from the input stage to the core.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsfm_pkg;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int BYTE_W                = 8;
    localparam int CFG_INDEX_W           = 2;
    localparam int CFG_DATA_W            = 64;
    localparam int LEN_FIELD_W           = 5;
    localparam int TIER_W                = 2;
    localparam int OUT_TDATA_W           = 8;

    localparam logic [BYTE_W-1:0] UNDERSCORE_BYTE = 8'h5F;
    localparam int                MIN_SUBWORD_LENGTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

    // Result tiers.
    typedef enum logic [TIER_W-1:0] {
        TIER_NONE    = 2'd0,
        TIER_FUZZY   = 2'd1,
        TIER_SUBWORD = 2'd2,
        TIER_PREFIX  = 2'd3
    } t_tier;

    // One candidate byte handed to the grading core.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [BYTE_W-1:0] cand;
    } t_item;

endpackage : tpsfm_pkg

`default_nettype wire

### hw/rtl/tpsfm_core.sv
// ----------------------------------------------------------------------------
// tpsfm_core : per-candidate grading state and tier decision
// Holds the position, prefix flag, subword and fuzzy counters of the
// candidate in progress, updates them for one byte and, on the last byte,
// gives the tier and returns to the start-of-candidate state.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsfm_core #(
    parameter int MAX_PATTERN_BYTES = tpsfm_pkg::DEF_MAX_PATTERN_BYTES
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire tpsfm_pkg::t_item                          i_item,
    input  wire logic [MAX_PATTERN_BYTES*tpsfm_pkg::BYTE_W-1:0] i_pattern,
    input  wire logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]    i_length,
    output logic                                           o_tier_valid,
    output tpsfm_pkg::t_tier                               o_tier
);
    import tpsfm_pkg::*;

    localparam int CW    = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IW    = $clog2(MAX_PATTERN_BYTES);
    localparam int DEPTH = 1 << IW;
    localparam logic [CW-1:0] MAX_COUNT  = CW'(MAX_PATTERN_BYTES);
    localparam logic [CW-1:0] MIN_SUBLEN = CW'(MIN_SUBWORD_LENGTH);

    logic [BYTE_W-1:0] pat [DEPTH];

    logic [CW-1:0] r_pos,    n_pos;
    logic          r_prefix, n_prefix;
    logic [CW-1:0] r_sub,    n_sub;
    logic [CW-1:0] r_fuzzy,  n_fuzzy;
    logic          r_start,  n_start;

    // Pad the byte table to a power of two so every index is in range.
    always_comb begin
        for (int b = 0; b < DEPTH; b++) begin
            if (b < MAX_PATTERN_BYTES) begin
                pat[b] = i_pattern[b*BYTE_W +: BYTE_W];
            end else begin
                pat[b] = '0;
            end
        end
    end

    always_comb begin
        n_prefix = r_prefix;
        n_sub    = r_sub;
        n_fuzzy  = r_fuzzy;
        n_pos    = r_pos;
        if (r_pos < i_length && i_item.cand != pat[r_pos[IW-1:0]]) begin
            n_prefix = 1'b0;
        end
        if (r_start && r_sub < i_length && i_item.cand == pat[r_sub[IW-1:0]]) begin
            n_sub = r_sub + CW'(1);
        end
        if (r_fuzzy < i_length && i_item.cand == pat[r_fuzzy[IW-1:0]]) begin
            n_fuzzy = r_fuzzy + CW'(1);
        end
        n_start = (i_item.cand == UNDERSCORE_BYTE);
        if (r_pos < MAX_COUNT) begin
            n_pos = r_pos + CW'(1);
        end
    end

    always_comb begin
        if (i_length == '0) begin
            o_tier = TIER_PREFIX;
        end else if (n_pos < i_length) begin
            o_tier = TIER_NONE;
        end else if (n_prefix) begin
            o_tier = TIER_PREFIX;
        end else if (i_length >= MIN_SUBLEN && n_sub == i_length) begin
            o_tier = TIER_SUBWORD;
        end else if (n_fuzzy == i_length) begin
            o_tier = TIER_FUZZY;
        end else begin
            o_tier = TIER_NONE;
        end
    end

    assign o_tier_valid = i_item.valid && i_item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_item.valid && i_item.last)) begin
            r_pos    <= '0;
            r_prefix <= 1'b1;
            r_sub    <= '0;
            r_fuzzy  <= '0;
            r_start  <= 1'b1;
        end else if (i_item.valid) begin
            r_pos    <= n_pos;
            r_prefix <= n_prefix;
            r_sub    <= n_sub;
            r_fuzzy  <= n_fuzzy;
            r_start  <= n_start;
        end
    end

endmodule : tpsfm_core

`default_nettype wire

### hw/rtl/tiered_prefix_subword_fuzzy_matcher.sv
// ----------------------------------------------------------------------------
// tiered_prefix_subword_fuzzy_matcher : grades candidate words against a pattern
// Candidate bytes stream in one item at a time; on the byte marked last the
// block returns one tier: exact prefix, subword, fuzzy or no match.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                    Payload
//  -------  ---  ---------------------------  --------------------------------
//  s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tdata = candidate_byte,
//                                             tlast = final_byte
//  m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata[1:0] = match_tier
//  cfg      in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One byte is taken in every cycle while the input register is not stalled. A byte
// is held in the input register, where the core grades it, and for the last
// byte of a candidate the tier is registered in the output register. Only a
// last byte needs the output register, so other bytes keep flowing while a
// tier waits to be taken; a last byte stalls in the input register until the
// output register frees up.
// Reset (synchronous, active low) clears the pattern, the pipeline and the
// candidate state. The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tiered_prefix_subword_fuzzy_matcher #(
    parameter int MAX_PATTERN_BYTES = tpsfm_pkg::DEF_MAX_PATTERN_BYTES
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Candidate stream.
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [tpsfm_pkg::BYTE_W-1:0]       i_s_axis_tdata,  // [7:0] candidate_byte
    input  wire logic                               i_s_axis_tlast,
    // Result stream.
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [tpsfm_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,  // [1:0] match_tier, rest zero
    // Configuration writes.
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tpsfm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [tpsfm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tpsfm_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN_BYTES + 1);
    localparam logic [LEN_FIELD_W-1:0] MAX_LEN = LEN_FIELD_W'(MAX_PATTERN_BYTES);
    localparam int HALF_BYTES = CFG_DATA_W / BYTE_W;

    // Pattern storage: only the bytes a legal length can reach are kept.
    logic [MAX_PATTERN_BYTES*BYTE_W-1:0] r_pattern;
    logic [CW-1:0]                       r_length;
    logic                                cfg_write;

    // Pipeline registers.
    t_item              r_in;
    logic               r_out_valid;
    t_tier              r_tier;

    t_item              core_item;
    logic               core_tier_valid;
    t_tier              core_tier;
    logic               drain;
    logic               in_accept;
    logic [LEN_FIELD_W-1:0] len_field;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;
    assign len_field   = i_cfg_data[LEN_FIELD_W-1:0];

    // Lengths above the pattern capacity behave as a full-length pattern, so
    // the clamp is applied once, at the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= '0;
        end else if (cfg_write) begin
            for (int b = 0; b < MAX_PATTERN_BYTES; b++) begin
                if (b < HALF_BYTES && i_cfg_index == CFG_PATTERN_LOW) begin
                    r_pattern[b*BYTE_W +: BYTE_W] <= i_cfg_data[b*BYTE_W +: BYTE_W];
                end else if (b >= HALF_BYTES && i_cfg_index == CFG_PATTERN_HIGH) begin
                    r_pattern[b*BYTE_W +: BYTE_W] <=
                        i_cfg_data[(b-HALF_BYTES)*BYTE_W +: BYTE_W];
                end
            end
            if (i_cfg_index == CFG_PATTERN_LEN) begin
                r_length <= (len_field > MAX_LEN) ? CW'(MAX_PATTERN_BYTES)
                                                  : len_field[CW-1:0];
            end
        end
    end

    // The held byte moves on unless it is a last byte and the output register
    // still holds an untaken tier.
    assign drain           = !r_in.last || !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in.valid || drain;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in <= '0;
        end else if (o_s_axis_tready) begin
            r_in.valid <= in_accept;
            r_in.last  <= i_s_axis_tlast;
            r_in.cand  <= i_s_axis_tdata;
        end
    end

    always_comb begin
        core_item       = r_in;
        core_item.valid = r_in.valid && drain;
    end

    tpsfm_core #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (core_item),
        .i_pattern    (r_pattern),
        .i_length     (r_length),
        .o_tier_valid (core_tier_valid),
        .o_tier       (core_tier)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_tier_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_tier_valid) begin
            r_tier <= core_tier;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-TIER_W){1'b0}}, r_tier};

endmodule : tiered_prefix_subword_fuzzy_matcher

`default_nettype wire

### hw/rtl/tpsfm_checker.sv
// ----------------------------------------------------------------------------
// tpsfm_checker : port-level checks for the fuzzy matcher
// Watches the stream and configuration ports and flags ordering or stall
// behaviour that the two-stage pipeline must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsfm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic       i_s_axis_tlast,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_cfg_ready
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result still valid after reset");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result dropped or changed");

    // A fresh result follows a last byte taken earlier, through the input and output registers.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, 2))
        else $error("result without a last byte two cycles earlier");

    // With the result register empty nothing may hold back the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready && o_cfg_ready)
        else $error("input stalled with an empty result register");

endmodule : tpsfm_checker

bind tiered_prefix_subword_fuzzy_matcher tpsfm_checker u_tpsfm_checker (.*);

`default_nettype wire

### verif/tiered_prefix_subword_fuzzy_matcher_test.sv
// ----------------------------------------------------------------------------
// tiered_prefix_subword_fuzzy_matcher_test : self-checking bench of the matcher
// Streams candidate words into the matcher and grades every item with its own
// model of the prefix, subword and fuzzy tiers. Each tier that comes out is
// compared with the oldest one predicted. The run starts with a few directed
// words and then moves through random patterns and four idling phases.
// ----------------------------------------------------------------------------
module tiered_prefix_subword_fuzzy_matcher_test;

    import tpsfm_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;      // pipeline is two deep, leave some margin
    localparam int HOLD_CYCLES    = 150;    // long receiver hold-off
    localparam int BATCH_ITEMS    = 50;
    localparam int POSITION_LIMIT = 16;
    localparam int TIMEOUT_CYCLES = 100000;

    // One item of the candidate stream as the driver sees it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_stream_byte;

    // Shapes of generated candidate words.
    typedef enum int {
        SHAPE_EXACT,
        SHAPE_SUBWORD,
        SHAPE_FUZZY,
        SHAPE_SHORT,
        SHAPE_NOISE,
        SHAPE_LONG
    } t_shape;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts at a known
    // value and reset is held low from time zero.
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [BYTE_W-1:0]      i_s_axis_tdata = '0;     // [7:0] candidate_byte
    logic                   i_s_axis_tlast = 1'b0;   // final_byte
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;          // [1:0] match_tier, rest zero
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    tiered_prefix_subword_fuzzy_matcher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state shared between the processes.
    // ------------------------------------------------------------------------
    t_stream_byte byte_queue[$];       // items waiting to be offered
    t_tier        tier_expected[$];    // tiers predicted but not yet seen
    int           mismatch_count = 0;
    logic         byte_taken = 1'b0;   // an item was accepted at the last edge
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    logic         hold_request = 1'b0;
    int           hold_count = 0;

    // Copy of the pattern registers, updated when a write is accepted.
    logic [CFG_DATA_W-1:0]  pattern_lo_q = '0;
    logic [CFG_DATA_W-1:0]  pattern_hi_q = '0;
    logic [LEN_FIELD_W-1:0] pattern_len_q = '0;

    // Grading state of the candidate in flight, at the widths of the block.
    logic [4:0] seen_count = '0;
    logic       prefix_equal = 1'b1;
    logic [4:0] subword_hits = '0;
    logic [4:0] fuzzy_hits = '0;
    logic       word_start = 1'b1;

    // ------------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------------

    // Lengths above the pattern store simply use the whole store.
    function automatic int live_length();
        if (pattern_len_q > DEF_MAX_PATTERN_BYTES)
            return DEF_MAX_PATTERN_BYTES;
        return pattern_len_q;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte_at(input int k);
        logic [3:0]            sel;
        logic [CFG_DATA_W-1:0] word;
        sel  = 4'(k);
        word = sel[3] ? pattern_hi_q : pattern_lo_q;
        return word[sel[2:0] * 8 +: 8];
    endfunction

    // Folds one accepted item into the candidate state. On the last byte the
    // tier is decided, queued as expected, and the state starts afresh. The
    // pattern used is whatever the registers hold at the moment of the item.
    task automatic grade_byte(input logic [BYTE_W-1:0] c, input logic last);
        int    len;
        t_tier tier;
        len = live_length();
        if (seen_count < len && c != pattern_byte_at(seen_count))
            prefix_equal = 1'b0;
        if (word_start && subword_hits < len && c == pattern_byte_at(subword_hits))
            subword_hits = subword_hits + 5'd1;
        if (fuzzy_hits < len && c == pattern_byte_at(fuzzy_hits))
            fuzzy_hits = fuzzy_hits + 5'd1;
        word_start = (c == UNDERSCORE_BYTE);
        if (seen_count < POSITION_LIMIT)
            seen_count = seen_count + 5'd1;
        if (last) begin
            if (len == 0)
                tier = TIER_PREFIX;
            else if (seen_count < len)
                tier = TIER_NONE;
            else if (prefix_equal)
                tier = TIER_PREFIX;
            else if (len >= MIN_SUBWORD_LENGTH && subword_hits == len)
                tier = TIER_SUBWORD;
            else if (fuzzy_hits == len)
                tier = TIER_FUZZY;
            else
                tier = TIER_NONE;
            tier_expected = {tier_expected, tier};
            seen_count   = '0;
            prefix_equal = 1'b1;
            subword_hits = '0;
            fuzzy_hits   = '0;
            word_start   = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge; inputs were set at
    // the falling edge before, and the block's outputs still show the values
    // they had going into the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tier wanted;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PATTERN_LOW:  pattern_lo_q = i_cfg_data;
                    CFG_PATTERN_HIGH: pattern_hi_q = i_cfg_data;
                    CFG_PATTERN_LEN:  pattern_len_q = i_cfg_data[LEN_FIELD_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                byte_taken = 1'b1;
                grade_byte(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (tier_expected.size() == 0) begin
                    $error("match_tier: expected no result, got %0d",
                           o_m_axis_tdata[TIER_W-1:0]);
                    mismatch_count++;
                end else begin
                    wanted = tier_expected.pop_front();
                    if (o_m_axis_tdata[TIER_W-1:0] !== wanted) begin
                        $error("match_tier: expected %0d, got %0d",
                               wanted, o_m_axis_tdata[TIER_W-1:0]);
                        mismatch_count++;
                    end
                    if (o_m_axis_tdata[OUT_TDATA_W-1:TIER_W] !== '0) begin
                        $error("tdata padding: expected 0, got %0h",
                               o_m_axis_tdata[OUT_TDATA_W-1:TIER_W]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item driver. A new item is offered only once the current one has been
    // taken; between items the sender may go idle at random.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_stream_byte next_byte;
        if (!i_s_axis_tvalid || byte_taken) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_byte = byte_queue.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= next_byte.data;
                i_s_axis_tlast  <= next_byte.last;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver. While a hold-off is requested it keeps tready low,
    // counting the hold-off itself up to HOLD_CYCLES; otherwise it stalls at random.
    always @(negedge i_clk) begin
        if (hold_request && hold_count < HOLD_CYCLES) begin
            hold_count      <= hold_count + 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (!hold_request)
                hold_count <= 0;
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void queue_byte(input logic [BYTE_W-1:0] data, input logic last);
        t_stream_byte item;
        item.data = data;
        item.last = last;
        byte_queue = {byte_queue, item};
    endfunction

    function automatic void queue_text(input string s, input logic finish);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], finish && (i == s.len() - 1));
    endfunction

    // Candidate bytes lean towards a few letters and the underscore so that
    // word starts and pattern hits are common; the rest cover the full range.
    function automatic logic [BYTE_W-1:0] pick_char();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return UNDERSCORE_BYTE;
        if (r < 6)
            return 8'($urandom_range(8'h64, 8'h61));
        return 8'($urandom_range(255));
    endfunction

    // Builds one candidate of the given shape from the current pattern and
    // queues it; returns the number of items added.
    function automatic int queue_candidate(input t_shape shape);
        logic [BYTE_W-1:0] cand[$];
        int                len;
        int                n;
        len = live_length();
        case (shape)
            SHAPE_EXACT: begin
                for (int k = 0; k < len; k++)
                    cand = {cand, pattern_byte_at(k)};
                n = $urandom_range(3);
                repeat (n) cand = {cand, pick_char()};
            end
            SHAPE_SUBWORD: begin
                // Each pattern byte opens a snake_case word.
                for (int k = 0; k < len; k++) begin
                    if (k > 0)
                        cand = {cand, UNDERSCORE_BYTE};
                    cand = {cand, pattern_byte_at(k)};
                    n = $urandom_range(2);
                    repeat (n) cand = {cand, 8'($urandom_range(8'h7A, 8'h61))};
                end
            end
            SHAPE_FUZZY: begin
                for (int k = 0; k < len; k++) begin
                    n = $urandom_range(2);
                    repeat (n) cand = {cand, pick_char()};
                    cand = {cand, pattern_byte_at(k)};
                end
                n = $urandom_range(2);
                repeat (n) cand = {cand, pick_char()};
            end
            SHAPE_SHORT: begin
                if (len >= 2) begin
                    n = $urandom_range(len - 1, 1);
                    for (int k = 0; k < n; k++)
                        cand = {cand, pattern_byte_at(k)};
                end
            end
            SHAPE_NOISE: begin
                n = $urandom_range(12, 1);
                repeat (n) cand = {cand, pick_char()};
            end
            default: begin
                // Longer than the position counter can count.
                n = $urandom_range(24, 17);
                repeat (n) cand = {cand, pick_char()};
            end
        endcase
        if (cand.size() == 0)
            cand = {cand, pick_char()};
        // Now and then one byte is spoilt so that the word only nearly matches.
        if ($urandom_range(7) == 0)
            cand[$urandom_range(cand.size() - 1)] = pick_char();
        foreach (cand[i])
            queue_byte(cand[i], i == cand.size() - 1);
        return cand.size();
    endfunction

    function automatic t_shape pick_shape();
        int r;
        r = $urandom_range(99);
        if (r < 25) return SHAPE_EXACT;
        if (r < 45) return SHAPE_SUBWORD;
        if (r < 65) return SHAPE_FUZZY;
        if (r < 75) return SHAPE_SHORT;
        if (r < 90) return SHAPE_NOISE;
        return SHAPE_LONG;
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0]  value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Fills all sixteen pattern bytes, unused ones too, and writes the three
    // registers in one of two orders, picked at random.
    task automatic load_pattern(input int len, input logic letters);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [BYTE_W-1:0]     b;
        for (int k = 0; k < DEF_MAX_PATTERN_BYTES; k++) begin
            b = letters ? 8'($urandom_range(8'h64, 8'h61)) : 8'($urandom_range(255));
            if (k < 8)
                lo[k * 8 +: 8] = b;
            else
                hi[(k - 8) * 8 +: 8] = b;
        end
        if ($urandom_range(1)) begin
            write_register(CFG_PATTERN_LEN, CFG_DATA_W'(len));
            write_register(CFG_PATTERN_HIGH, hi);
            write_register(CFG_PATTERN_LOW, lo);
        end else begin
            write_register(CFG_PATTERN_LOW, lo);
            write_register(CFG_PATTERN_HIGH, hi);
            write_register(CFG_PATTERN_LEN, CFG_DATA_W'(len));
        end
    endtask

    // Waits until every queued item has been taken and every predicted tier
    // has come back, then lets the pipeline settle; a byte that ends no word
    // may still be inside the block at that point.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || i_s_axis_tvalid || tier_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    int setting_lengths[8] = '{16, 3, 0, 31, 1, 2, 17, 6};

    initial begin
        int added;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words. After reset the pattern is empty, so any word is an
        // exact prefix.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_text("x", 1'b1);
        wait_drained();

        // Pattern "ab": exact, too short, subword and fuzzy words.
        write_register(CFG_PATTERN_LOW, 64'h0000_0000_0000_6261);
        write_register(CFG_PATTERN_HIGH, '0);
        write_register(CFG_PATTERN_LEN, 64'd2);
        queue_text("ab", 1'b1);
        queue_text("a", 1'b1);
        queue_text("a_b", 1'b1);
        queue_text("xab", 1'b1);

        // The length shrinks while a word is half way through.
        queue_text("a", 1'b0);
        wait_drained();
        write_register(CFG_PATTERN_LEN, 64'd1);
        queue_text("z", 1'b1);

        // A one-byte pattern never gives the subword tier, even when the byte
        // opens a word.
        queue_text("x_a", 1'b1);
        wait_drained();

        // A length beyond the store acts as the full sixteen bytes.
        write_register(CFG_PATTERN_LOW, '1);
        write_register(CFG_PATTERN_HIGH, '1);
        write_register(CFG_PATTERN_LEN, 64'd31);
        queue_text("abc", 1'b1);

        // Random part: four idling phases, two pattern settings in each.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 56; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            for (int half = 0; half < 2; half++) begin
                // The sender pauses here until every tier is back, which also
                // makes it safe to rewrite the pattern.
                wait_drained();
                load_pattern(setting_lengths[phase * 2 + half], (phase + half) % 2 == 0);

                if (phase == 0 && half == 0) begin
                    // Hold the result side off for a long stretch while short
                    // words keep coming, so the output register fills and
                    // the input side has to stall.
                    hold_request = 1'b1;
                    repeat (30) queue_byte(pick_char(), 1'b1);
                    while (hold_count < HOLD_CYCLES)
                        @(posedge i_clk);
                    hold_request = 1'b0;
                    wait_drained();
                end

                added = 0;
                while (added < BATCH_ITEMS)
                    added += queue_candidate(pick_shape());
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("tiered_prefix_subword_fuzzy_matcher_test: clean");
        else
            $display("tiered_prefix_subword_fuzzy_matcher_test: errors");
        $finish;
    end

    // Watchdog: a tier that never arrives or a stuck handshake ends here.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tiered_prefix_subword_fuzzy_matcher_test: errors");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tpsfm_pkg.sv
hw/rtl/tpsfm_core.sv
hw/rtl/tiered_prefix_subword_fuzzy_matcher.sv
hw/rtl/tpsfm_checker.sv
verif/tiered_prefix_subword_fuzzy_matcher_test.sv
